@@ design/crs_pkg.sv @@
// Shared types, constants and helper functions for the CSS rule splitter
// No dependencies; imported by every other file of the block
package crs_pkg;

  // default sizing, handed down from the top level
  localparam int MAX_RULES_DEF   = 512;
  localparam int OFFSET_BITS_DEF = 20;
  localparam int DEPTH_BITS_DEF  = 16;

  // fixed widths of the result fields
  localparam int FIELD_OFF_W = 20;
  localparam int FIELD_CNT_W = 10;

  // depth of the result queue
  localparam int RES_DEPTH = 4;

  typedef logic [7:0] char_t;

  // byte codes the scanner reacts to
  localparam char_t CH_SLASH = 8'h2F;
  localparam char_t CH_STAR  = 8'h2A;
  localparam char_t CH_BSL   = 8'h5C;
  localparam char_t CH_DQ    = 8'h22;
  localparam char_t CH_SQ    = 8'h27;
  localparam char_t CH_LBR   = 8'h7B;
  localparam char_t CH_RBR   = 8'h7D;
  localparam char_t CH_SEMI  = 8'h3B;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0D;

  // at-rule patterns for the foundational flag
  localparam int PAT_NUM     = 3;
  localparam int PAT_MAX_LEN = 18;
  localparam int PAT_IDX_W   = 5;

  localparam logic [PAT_IDX_W-1:0] PAT_LEN [PAT_NUM] = '{5'd10, 5'd10, 5'd18};

  localparam char_t PAT_FONT [PAT_MAX_LEN] = '{
    "@", "f", "o", "n", "t", "-", "f", "a", "c", "e",
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam char_t PAT_KEY [PAT_MAX_LEN] = '{
    "@", "k", "e", "y", "f", "r", "a", "m", "e", "s",
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam char_t PAT_WK [PAT_MAX_LEN] = '{
    "@", "-", "w", "e", "b", "k", "i", "t", "-",
    "k", "e", "y", "f", "r", "a", "m", "e", "s"};

  // result kinds
  typedef enum logic [1:0] {
    KIND_RULE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // one input item
  typedef struct packed {
    char_t css_byte;
    logic  is_final;
  } item_t;

  // one result item
  typedef struct packed {
    kind_t                  kind;
    logic [FIELD_OFF_W-1:0] rule_begin;
    logic [FIELD_OFF_W-1:0] rule_stop;
    logic                   is_foundational;
    logic [FIELD_CNT_W-1:0] total_rules;
    logic                   run_end;
  } res_t;

  // results of one step, rule first then status
  typedef struct packed {
    logic rule_v;
    logic stat_v;
    res_t rule_res;
    res_t stat_res;
  } push_t;

  // pattern byte lookup, idx below PAT_MAX_LEN
  function automatic char_t pat_char(input int unsigned which,
                                     input logic [PAT_IDX_W-1:0] idx);
    char_t ch;
    ch = 8'h00;
    if (idx < PAT_IDX_W'(PAT_MAX_LEN)) begin
      unique case (which)
        0:       ch = PAT_FONT[idx];
        1:       ch = PAT_KEY[idx];
        default: ch = PAT_WK[idx];
      endcase
    end
    return ch;
  endfunction

  // space, tab, line feed, vertical tab, form feed, carriage return
  function automatic logic is_ws(input char_t c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

@@ design/crs_in_if.sv @@
// Input channel of the rule splitter: one stylesheet byte per item
// Depends on crs_pkg
interface crs_in_if import crs_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t css_byte;
  logic  is_final;

  modport source (output valid, output css_byte, output is_final, input ready);
  modport sink   (input valid, input css_byte, input is_final, output ready);
endinterface

@@ design/crs_out_if.sv @@
// Result channel of the rule splitter: rule spans and final status
// Depends on crs_pkg
interface crs_out_if import crs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  kind_t                  kind;
  logic [FIELD_OFF_W-1:0] rule_begin;
  logic [FIELD_OFF_W-1:0] rule_stop;
  logic                   is_foundational;
  logic [FIELD_CNT_W-1:0] total_rules;
  logic                   run_end;

  modport source (output valid, output kind, output rule_begin, output rule_stop,
                  output is_foundational, output total_rules, output run_end,
                  input ready);
  modport sink   (input valid, input kind, input rule_begin, input rule_stop,
                  input is_foundational, input total_rules, input run_end,
                  output ready);
endinterface

@@ design/crs_in_stage.sv @@
// Input register of the rule splitter; holds one item until the scanner takes it
// Depends on crs_pkg and crs_in_if
module crs_in_stage import crs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  crs_in_if.sink     in_chan,
  input  logic       adv,
  output logic       item_v,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  // free when empty or when the held item moves on this cycle
  assign in_chan.ready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.css_byte <= in_chan.css_byte;
      item_r.is_final <= in_chan.is_final;
    end
  end

  assign item_v = valid_r;
  assign item   = item_r;

endmodule

@@ design/crs_step.sv @@
// Scanner state and per-byte update: comments, strings, braces, lead match
// Depends on crs_pkg
module crs_step import crs_pkg::*; #(
  parameter int MAX_RULES   = MAX_RULES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  item_t item,
  output push_t push
);

  localparam int RULE_W = $clog2(MAX_RULES + 1);

  // scanner state
  logic [OFFSET_BITS-1:0] byte_position_r, byte_position_nxt;
  logic [OFFSET_BITS-1:0] segment_start_r, segment_start_nxt;
  logic [DEPTH_BITS-1:0]  brace_depth_r, brace_depth_nxt;
  logic                   in_string_r, in_string_nxt;
  logic                   string_delim_double_r, string_delim_double_nxt;
  logic                   escape_pending_r, escape_pending_nxt;
  logic                   in_comment_r, in_comment_nxt;
  logic                   star_seen_r, star_seen_nxt;
  logic                   slash_seen_r, slash_seen_nxt;
  logic                   lead_seen_r, lead_seen_nxt;
  logic [PAT_IDX_W-1:0]   match_index_r, match_index_nxt;
  logic [PAT_NUM-1:0]     match_alive_r, match_alive_nxt;
  logic                   foundational_hit_r, foundational_hit_nxt;
  logic [RULE_W-1:0]      rules_found_r, rules_found_nxt;
  logic                   error_seen_r, error_seen_nxt;

  // per-step values
  char_t                  c;
  logic [OFFSET_BITS-1:0] stop_p;
  logic [PAT_IDX_W-1:0]   midx_eff;
  logic                   rule_v;
  logic                   rule_fnd;
  logic                   stat_v;
  logic                   stat_bad;
  logic [OFFSET_BITS+FIELD_OFF_W-1:0] begin_ext;
  logic [OFFSET_BITS+FIELD_OFF_W-1:0] stop_ext;
  logic [RULE_W+FIELD_CNT_W-1:0]      total_ext;

  assign c      = item.css_byte;
  assign stop_p = byte_position_r + 1'b1;

  // one byte of scanning, then the end-of-stream status and restart
  always_comb begin
    byte_position_nxt       = byte_position_r;
    segment_start_nxt       = segment_start_r;
    brace_depth_nxt         = brace_depth_r;
    in_string_nxt           = in_string_r;
    string_delim_double_nxt = string_delim_double_r;
    escape_pending_nxt      = escape_pending_r;
    in_comment_nxt          = in_comment_r;
    star_seen_nxt           = star_seen_r;
    slash_seen_nxt          = slash_seen_r;
    lead_seen_nxt           = lead_seen_r;
    match_index_nxt         = match_index_r;
    match_alive_nxt         = match_alive_r;
    foundational_hit_nxt    = foundational_hit_r;
    rules_found_nxt         = rules_found_r;
    error_seen_nxt          = error_seen_r;
    midx_eff                = '0;
    rule_v                  = 1'b0;
    rule_fnd                = 1'b0;
    stat_v                  = 1'b0;
    stat_bad                = 1'b0;

    if (adv) begin
      if (!error_seen_r) begin
        if (byte_position_r == '1) begin
          // offset overflow
          error_seen_nxt = 1'b1;
        end else begin
          byte_position_nxt = stop_p;

          // leading at-rule match, on raw bytes
          if (lead_seen_r || !is_ws(c)) begin
            lead_seen_nxt   = 1'b1;
            midx_eff        = lead_seen_r ? match_index_r : '0;
            match_index_nxt = midx_eff;
            if (!foundational_hit_r && (match_alive_r != '0) &&
                (midx_eff < PAT_IDX_W'(PAT_MAX_LEN))) begin
              for (int k = 0; k < PAT_NUM; k++) begin
                if (match_alive_r[k]) begin
                  if ((midx_eff >= PAT_LEN[k]) || (pat_char(k, midx_eff) != c)) begin
                    match_alive_nxt[k] = 1'b0;
                  end else if ((midx_eff + 1'b1) == PAT_LEN[k]) begin
                    foundational_hit_nxt = 1'b1;
                  end
                end
              end
              match_index_nxt = midx_eff + 1'b1;
            end
          end

          // lexical state
          if (in_comment_r) begin
            if (star_seen_r && (c == CH_SLASH)) begin
              in_comment_nxt = 1'b0;
              star_seen_nxt  = 1'b0;
            end else begin
              star_seen_nxt = (c == CH_STAR);
            end
          end else if (in_string_r) begin
            if (escape_pending_r) begin
              escape_pending_nxt = 1'b0;
            end else if (c == CH_BSL) begin
              escape_pending_nxt = 1'b1;
            end else if (c == (string_delim_double_r ? CH_DQ : CH_SQ)) begin
              in_string_nxt = 1'b0;
            end
          end else if (slash_seen_r && (c == CH_STAR)) begin
            slash_seen_nxt = 1'b0;
            in_comment_nxt = 1'b1;
            star_seen_nxt  = 1'b0;
          end else begin
            slash_seen_nxt = 1'b0;
            if (c == CH_SLASH) begin
              slash_seen_nxt = 1'b1;
            end else if ((c == CH_SQ) || (c == CH_DQ)) begin
              in_string_nxt           = 1'b1;
              string_delim_double_nxt = (c == CH_DQ);
              escape_pending_nxt      = 1'b0;
            end else if (c == CH_LBR) begin
              if (brace_depth_r == '1) begin
                error_seen_nxt = 1'b1;
              end else begin
                brace_depth_nxt = brace_depth_r + 1'b1;
              end
            end else if (c == CH_RBR) begin
              if (brace_depth_r == '0) begin
                // unmatched close brace
                error_seen_nxt = 1'b1;
              end else begin
                brace_depth_nxt = brace_depth_r - 1'b1;
                if (brace_depth_r == DEPTH_BITS'(1)) begin
                  if (rules_found_r >= RULE_W'(MAX_RULES)) begin
                    error_seen_nxt = 1'b1;
                  end else begin
                    rule_v               = 1'b1;
                    rule_fnd             = lead_seen_nxt && foundational_hit_nxt;
                    rules_found_nxt      = rules_found_r + 1'b1;
                    segment_start_nxt    = stop_p;
                    lead_seen_nxt        = 1'b0;
                    match_index_nxt      = '0;
                    match_alive_nxt      = '1;
                    foundational_hit_nxt = 1'b0;
                  end
                end
              end
            end else if ((c == CH_SEMI) && (brace_depth_r == '0)) begin
              segment_start_nxt    = stop_p;
              lead_seen_nxt        = 1'b0;
              match_index_nxt      = '0;
              match_alive_nxt      = '1;
              foundational_hit_nxt = 1'b0;
            end
          end
        end
      end

      // final byte: status, then back to reset state
      if (item.is_final) begin
        stat_v   = 1'b1;
        stat_bad = error_seen_nxt || (brace_depth_nxt != '0) ||
                   in_string_nxt || in_comment_nxt;
        byte_position_nxt       = '0;
        segment_start_nxt       = '0;
        brace_depth_nxt         = '0;
        in_string_nxt           = 1'b0;
        string_delim_double_nxt = 1'b0;
        escape_pending_nxt      = 1'b0;
        in_comment_nxt          = 1'b0;
        star_seen_nxt           = 1'b0;
        slash_seen_nxt          = 1'b0;
        lead_seen_nxt           = 1'b0;
        match_index_nxt         = '0;
        match_alive_nxt         = '1;
        foundational_hit_nxt    = 1'b0;
        rules_found_nxt         = '0;
        error_seen_nxt          = 1'b0;
      end
    end
  end

  // result fields, fitted to the fixed port widths
  assign begin_ext = {{FIELD_OFF_W{1'b0}}, segment_start_r};
  assign stop_ext  = {{FIELD_OFF_W{1'b0}}, stop_p};
  assign total_ext = {{FIELD_CNT_W{1'b0}}, rules_found_r + RULE_W'(rule_v)};

  always_comb begin
    push.rule_v                   = rule_v;
    push.stat_v                   = stat_v;
    push.rule_res.kind            = KIND_RULE;
    push.rule_res.rule_begin      = begin_ext[FIELD_OFF_W-1:0];
    push.rule_res.rule_stop       = stop_ext[FIELD_OFF_W-1:0];
    push.rule_res.is_foundational = rule_fnd;
    push.rule_res.total_rules     = '0;
    push.rule_res.run_end         = 1'b0;
    push.stat_res.kind            = stat_bad ? KIND_ERR : KIND_OK;
    push.stat_res.rule_begin      = '0;
    push.stat_res.rule_stop       = '0;
    push.stat_res.is_foundational = 1'b0;
    push.stat_res.total_rules     = total_ext[FIELD_CNT_W-1:0];
    push.stat_res.run_end         = 1'b1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r       <= '0;
      segment_start_r       <= '0;
      brace_depth_r         <= '0;
      in_string_r           <= 1'b0;
      string_delim_double_r <= 1'b0;
      escape_pending_r      <= 1'b0;
      in_comment_r          <= 1'b0;
      star_seen_r           <= 1'b0;
      slash_seen_r          <= 1'b0;
      lead_seen_r           <= 1'b0;
      match_index_r         <= '0;
      match_alive_r         <= '1;
      foundational_hit_r    <= 1'b0;
      rules_found_r         <= '0;
      error_seen_r          <= 1'b0;
    end else begin
      byte_position_r       <= byte_position_nxt;
      segment_start_r       <= segment_start_nxt;
      brace_depth_r         <= brace_depth_nxt;
      in_string_r           <= in_string_nxt;
      string_delim_double_r <= string_delim_double_nxt;
      escape_pending_r      <= escape_pending_nxt;
      in_comment_r          <= in_comment_nxt;
      star_seen_r           <= star_seen_nxt;
      slash_seen_r          <= slash_seen_nxt;
      lead_seen_r           <= lead_seen_nxt;
      match_index_r         <= match_index_nxt;
      match_alive_r         <= match_alive_nxt;
      foundational_hit_r    <= foundational_hit_nxt;
      rules_found_r         <= rules_found_nxt;
      error_seen_r          <= error_seen_nxt;
    end
  end

  // a final byte leaves the scanner in its reset state
  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.is_final |=> (byte_position_r == '0) && (brace_depth_r == '0) &&
                             !error_seen_r && (rules_found_r == '0))
    else $error("scanner state not cleared after final byte");

  // an error holds until the end of the stream
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    error_seen_r && !(adv && item.is_final) |=> error_seen_r)
    else $error("error flag dropped before end of stream");

  // a rule closes only at depth one and spans at least one byte
  a_rule_span: assert property (@(posedge clk) disable iff (!rst_n)
    push.rule_v |-> (brace_depth_r == DEPTH_BITS'(1)) && (segment_start_r < stop_p))
    else $error("rule emitted with bad depth or span");

  // nothing is produced without a byte moving in
  a_push_needs_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (push.rule_v || push.stat_v) |-> adv)
    else $error("result produced without an item");

endmodule

@@ design/crs_res_fifo.sv @@
// Small result queue: takes up to two results per cycle, hands out one
// Depends on crs_pkg and crs_out_if
module crs_res_fifo import crs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       room,
  crs_out_if.source  out_chan
);

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  res_t             mem_r [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] stat_ptr;
  logic             pop;
  logic [CNT_W-1:0] n_push;

  // two free slots cover the worst case of one item
  assign room     = count_r <= CNT_W'(RES_DEPTH - 2);
  assign pop      = out_chan.valid && out_chan.ready;
  assign n_push   = CNT_W'(push.rule_v) + CNT_W'(push.stat_v);
  assign stat_ptr = push.rule_v ? wr_ptr_r + 1'b1 : wr_ptr_r;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, rule ahead of status
  always_ff @(posedge clk) begin
    if (push.rule_v) begin
      mem_r[wr_ptr_r] <= push.rule_res;
    end
    if (push.stat_v) begin
      mem_r[stat_ptr] <= push.stat_res;
    end
  end

  // head of queue drives the channel
  assign out_chan.valid           = count_r != '0;
  assign out_chan.kind            = mem_r[rd_ptr_r].kind;
  assign out_chan.rule_begin      = mem_r[rd_ptr_r].rule_begin;
  assign out_chan.rule_stop       = mem_r[rd_ptr_r].rule_stop;
  assign out_chan.is_foundational = mem_r[rd_ptr_r].is_foundational;
  assign out_chan.total_rules     = mem_r[rd_ptr_r].total_rules;
  assign out_chan.run_end         = mem_r[rd_ptr_r].run_end;

  // never written beyond capacity
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != '0) |-> room)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RES_DEPTH))
    else $error("result queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(count_r))
    else $error("result queue pointers disagree with count");

endmodule

@@ design/css_top_level_rule_splitter.sv @@
// Splits a CSS stylesheet, fed one byte per item, into its top-level rules and
// reports a final status with the rule count on the last byte. After the input
// register each byte goes through a single pass of scanner logic, and its
// results (a rule span, the status, or both) enter a four-entry result queue.
// A byte moves on whenever the queue has two free slots, so with the result
// side ready the block sustains one byte per clock. A byte is registered in
// the input stage and its results in the queue before they reach the output.
// No clearing pass is needed after reset. Depends on crs_pkg, crs_in_if,
// crs_out_if and the crs_in_stage, crs_step and crs_res_fifo modules.
module css_top_level_rule_splitter import crs_pkg::*; #(
  parameter int MAX_RULES   = MAX_RULES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  crs_in_if.sink     in_chan,
  crs_out_if.source  out_chan
);

  logic  item_v;
  item_t item;
  logic  room;
  logic  adv;
  push_t push;

  // the held byte is scanned when the queue can take its results
  assign adv = item_v && room;

  crs_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .adv     (adv),
    .item_v  (item_v),
    .item    (item)
  );

  crs_step #(
    .MAX_RULES   (MAX_RULES),
    .OFFSET_BITS (OFFSET_BITS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item),
    .push  (push)
  );

  crs_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for css_top_level_rule_splitter: streams stylesheets
// byte by byte and checks every rule span and final status against a predictor
// Depends on crs_pkg, crs_in_if, crs_out_if and the block's own design files
module tb_top;
  import crs_pkg::*;

  localparam int OFF_W        = OFFSET_BITS_DEF;
  localparam int DEP_W        = DEPTH_BITS_DEF;
  localparam int AT_RULE_SPAN = 18;    // longest at-rule name that is tracked
  localparam int RANDOM_ITEMS = 900;
  localparam int WATCHDOG     = 400;
  localparam int TAIL_CYCLES  = 16;

  localparam logic [OFF_W-1:0] OFF_LAST = '1;
  localparam logic [DEP_W-1:0] DEP_LAST = '1;

  // bytes the splitter reacts to
  localparam char_t C_SLASH = 8'h2F;
  localparam char_t C_STAR  = 8'h2A;
  localparam char_t C_BSL   = 8'h5C;
  localparam char_t C_DQ    = 8'h22;
  localparam char_t C_SQ    = 8'h27;
  localparam char_t C_LBR   = 8'h7B;
  localparam char_t C_RBR   = 8'h7D;
  localparam char_t C_SEMI  = 8'h3B;
  localparam char_t C_SPACE = 8'h20;

  localparam res_t NO_WANT = '0;

  // one row of the directed script
  typedef struct packed {
    char_t             b;
    logic              fin;
    logic              typed;
    kind_t             k;
    logic [FIELD_CNT_W-1:0] total;
  } step_row_t;

  logic clk;
  logic rst_n;
  bit   quiet;
  int unsigned faults;
  int unsigned idle_cycles;

  res_t      due_reports[$];
  char_t     sheet[$];
  step_row_t script[$];

  // splitter state as predicted
  logic [OFF_W-1:0] pos_q;
  logic [OFF_W-1:0] span_start;
  logic [DEP_W-1:0] nest;
  bit in_str, dq_str, esc, in_cmt, star, slash, lead;
  int unsigned at_idx;
  logic [2:0] at_alive;
  bit at_hit;
  int unsigned n_rules;
  bit broken;

  crs_in_if  in_ch ();
  crs_out_if out_ch ();

  css_top_level_rule_splitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic string at_rule_name(input int k);
    case (k)
      0:       return "@font-face";
      1:       return "@keyframes";
      default: return "@-webkit-keyframes";
    endcase
  endfunction

  function automatic void restart_span(input logic [OFF_W-1:0] at);
    span_start = at;
    lead       = 0;
    at_idx     = 0;
    at_alive   = '1;
    at_hit     = 0;
  endfunction

  function automatic void clear_split_state();
    pos_q   = '0;
    nest    = '0;
    in_str  = 0;
    dq_str  = 0;
    esc     = 0;
    in_cmt  = 0;
    star    = 0;
    slash   = 0;
    n_rules = 0;
    broken  = 0;
    restart_span('0);
  endfunction

  // follows the leading bytes of a rule against the at-rule names, raw
  function automatic void track_at_rule(input char_t c);
    string name;
    if (!lead) begin
      if (c == C_SPACE || (c >= 8'h09 && c <= 8'h0D)) return;
      lead   = 1;
      at_idx = 0;
    end
    if (at_hit || at_alive == '0 || at_idx >= AT_RULE_SPAN) return;
    for (int k = 0; k < 3; k++) begin
      name = at_rule_name(k);
      if (at_alive[k]) begin
        if (at_idx >= name.len() || char_t'(name[at_idx]) != c) at_alive[k] = 0;
        else if (at_idx + 1 == name.len()) at_hit = 1;
      end
    end
    at_idx++;
  endfunction

  // one byte in, its rule span and status (if any) queued as due
  function automatic void split_step(input char_t c, input bit fin);
    logic [OFF_W-1:0] p;
    res_t r;
    if (!broken) begin
      if (pos_q == OFF_LAST) begin
        broken = 1;
      end else begin
        p     = pos_q;
        pos_q = p + 1'b1;
        track_at_rule(c);
        if (in_cmt) begin
          if (star && c == C_SLASH) begin
            in_cmt = 0;
            star   = 0;
          end else begin
            star = (c == C_STAR);
          end
        end else if (in_str) begin
          if (esc) esc = 0;
          else if (c == C_BSL) esc = 1;
          else if (c == (dq_str ? C_DQ : C_SQ)) in_str = 0;
        end else if (slash && c == C_STAR) begin
          slash  = 0;
          in_cmt = 1;
          star   = 0;
        end else begin
          slash = 0;
          if (c == C_SLASH) begin
            slash = 1;
          end else if (c == C_SQ || c == C_DQ) begin
            in_str = 1;
            dq_str = (c == C_DQ);
            esc    = 0;
          end else if (c == C_LBR) begin
            if (nest == DEP_LAST) broken = 1;
            else nest++;
          end else if (c == C_RBR) begin
            if (nest == '0) begin
              broken = 1;
            end else begin
              nest--;
              if (nest == '0) begin
                if (n_rules >= MAX_RULES_DEF) begin
                  broken = 1;
                end else begin
                  r                 = '0;
                  r.kind            = KIND_RULE;
                  r.rule_begin      = span_start;
                  r.rule_stop       = p + 1'b1;
                  r.is_foundational = lead && at_hit;
                  due_reports.push_back(r);
                  n_rules++;
                  restart_span(p + 1'b1);
                end
              end
            end
          end else if (c == C_SEMI && nest == '0) begin
            restart_span(p + 1'b1);
          end
        end
      end
    end
    if (fin) begin
      r             = '0;
      r.kind        = (broken || nest != '0 || in_str || in_cmt) ? KIND_ERR : KIND_OK;
      r.total_rules = FIELD_CNT_W'(n_rules);
      r.run_end     = 1'b1;
      due_reports.push_back(r);
      clear_split_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stylesheet generation
  // ---------------------------------------------------------------------------

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) sheet.push_back(char_t'(s[i]));
  endfunction

  function automatic void put_ws(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) sheet.push_back(char_t'($urandom_range(9, 13)));
      else sheet.push_back(C_SPACE);
    end
  endfunction

  function automatic void put_comment();
    sheet.push_back(C_SLASH);
    sheet.push_back(C_STAR);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 5))
        0:       sheet.push_back(C_STAR);
        1:       sheet.push_back(C_RBR);
        2:       sheet.push_back(C_LBR);
        3:       sheet.push_back(C_SEMI);
        4:       sheet.push_back(C_DQ);
        default: put_text("x@");
      endcase
    end
    sheet.push_back(C_STAR);
    sheet.push_back(C_SLASH);
  endfunction

  function automatic void put_quoted();
    char_t q;
    q = $urandom_range(0, 1) ? C_DQ : C_SQ;
    sheet.push_back(q);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 5))
        0: begin
          sheet.push_back(C_BSL);
          sheet.push_back(q);
        end
        1: begin
          sheet.push_back(C_BSL);
          sheet.push_back(C_BSL);
        end
        2:       sheet.push_back(q == C_DQ ? C_SQ : C_DQ);
        3:       sheet.push_back(C_RBR);
        4:       sheet.push_back(C_LBR);
        default: put_text("a;/*");
      endcase
    end
    sheet.push_back(q);
  endfunction

  function automatic string pick_prelude();
    case ($urandom_range(0, 11))
      0:       return "@font-face";
      1:       return "@keyframes spin";
      2:       return "@-webkit-keyframes spin";
      3:       return "@font-fac";
      4:       return "@keyframe";
      5:       return "@-webkit-keyframe";
      6:       return "@font-face2";
      7:       return "@media screen";
      8:       return "a.b > c";
      9:       return "@-webkit-key";
      10:      return "@Font-face";
      default: return "#id";
    endcase
  endfunction

  function automatic void put_body(input int level);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: put_text("color:red;");
        1: put_ws($urandom_range(1, 2));
        2: put_comment();
        3: put_quoted();
        default: begin
          if (level < 2) begin
            put_text("to");
            sheet.push_back(C_LBR);
            put_body(level + 1);
            sheet.push_back(C_RBR);
          end
        end
      endcase
    end
  endfunction

  function automatic void put_rule();
    put_ws($urandom_range(0, 2));
    if ($urandom_range(0, 7) == 0) put_comment();
    put_text(pick_prelude());
    put_ws($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) begin
      sheet.push_back(C_SEMI);
    end else begin
      sheet.push_back(C_LBR);
      put_body(0);
      sheet.push_back(C_RBR);
    end
  endfunction

  // mostly well-formed sheets; some get noise bytes, a stray brace or a cut end
  function automatic void make_sheet();
    sheet.delete();
    repeat ($urandom_range(1, 4)) put_rule();
    put_ws($urandom_range(0, 2));
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4))
        sheet.insert($urandom_range(0, sheet.size()), char_t'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 9))
      0: sheet.insert($urandom_range(0, sheet.size()), C_RBR);
      1: begin
        repeat ($urandom_range(1, 5)) if (sheet.size() > 1) void'(sheet.pop_back());
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  function automatic res_t status_of(input kind_t k, input int total);
    res_t r;
    r             = '0;
    r.kind        = k;
    r.total_rules = FIELD_CNT_W'(total);
    r.run_end     = 1'b1;
    return r;
  endfunction

  task automatic add_row(input char_t b, input bit fin, input bit typed,
                         input kind_t k, input int total);
    step_row_t row;
    row.b     = b;
    row.fin   = fin;
    row.typed = typed;
    row.k     = k;
    row.total = FIELD_CNT_W'(total);
    script.push_back(row);
  endtask

  // offer one byte, hold it until taken, then book what it should give
  task automatic feed(input char_t b, input bit fin, input bit typed, input res_t want);
    int unsigned gap;
    int unsigned mark;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.css_byte = b;
    in_ch.is_final = fin;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    mark = due_reports.size();
    split_step(b, fin);
    if (typed) begin
      while (due_reports.size() > mark) void'(due_reports.pop_back());
      due_reports.push_back(want);
    end
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, checking and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned hold;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_ch.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_reports.size() == 0) begin
        $error("unexpected result: kind %0d", out_ch.kind);
        faults++;
      end else begin
        want = due_reports.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          faults++;
        end
        if (out_ch.rule_begin !== want.rule_begin) begin
          $error("rule_begin: expected %0d, got %0d", want.rule_begin, out_ch.rule_begin);
          faults++;
        end
        if (out_ch.rule_stop !== want.rule_stop) begin
          $error("rule_stop: expected %0d, got %0d", want.rule_stop, out_ch.rule_stop);
          faults++;
        end
        if (out_ch.is_foundational !== want.is_foundational) begin
          $error("is_foundational: expected %0d, got %0d",
                 want.is_foundational, out_ch.is_foundational);
          faults++;
        end
        if (out_ch.total_rules !== want.total_rules) begin
          $error("total_rules: expected %0d, got %0d", want.total_rules, out_ch.total_rules);
          faults++;
        end
        if (out_ch.run_end !== want.run_end) begin
          $error("run_end: expected %0d, got %0d", want.run_end, out_ch.run_end);
          faults++;
        end
      end
    end
  end

  // stop a hung run: count cycles in which neither side moves an item
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int sent;
    step_row_t row;
    rst_n          = 1'b0;
    quiet          = 0;
    faults         = 0;
    idle_cycles    = 0;
    in_ch.valid    = 1'b0;
    in_ch.css_byte = '0;
    in_ch.is_final = 1'b0;
    clear_split_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: single-byte sheets, open constructs at the end, error paths
    add_row(C_RBR,   0, 0, KIND_OK,  0);  // unmatched close brace
    add_row(C_LBR,   0, 0, KIND_OK,  0);  // swallowed after the error
    add_row(C_RBR,   1, 1, KIND_ERR, 0);
    add_row(8'h00,   1, 1, KIND_OK,  0);
    add_row(8'hFF,   1, 1, KIND_OK,  0);
    add_row(C_LBR,   1, 1, KIND_ERR, 0);  // block left open
    add_row(C_DQ,    0, 0, KIND_OK,  0);
    add_row(C_BSL,   1, 1, KIND_ERR, 0);  // backslash as the last string byte
    add_row(C_SLASH, 0, 0, KIND_OK,  0);
    add_row(C_STAR,  1, 1, KIND_ERR, 0);  // comment left open
    add_row(C_SQ,    0, 0, KIND_OK,  0);
    add_row("x",     1, 1, KIND_ERR, 0);  // single-quoted string left open
    add_row(C_SPACE, 0, 0, KIND_OK,  0);
    add_row(C_LBR,   0, 0, KIND_OK,  0);
    add_row(C_RBR,   1, 0, KIND_OK,  0);  // rule and status from one byte
    add_row(C_SEMI,  0, 0, KIND_OK,  0);  // restarts the rule start
    add_row(C_LBR,   0, 0, KIND_OK,  0);
    add_row(C_RBR,   0, 0, KIND_OK,  0);
    add_row(C_RBR,   1, 1, KIND_ERR, 1);  // the rule before the error stays
    foreach (script[i]) begin
      row = script[i];
      feed(row.b, row.fin, row.typed, status_of(row.k, row.total));
    end

    // rule count limit, run without idling
    quiet = 1;
    for (int i = 0; i <= MAX_RULES_DEF; i++) begin
      feed(C_LBR, 0, 0, NO_WANT);
      feed(C_RBR, 0, 0, NO_WANT);
    end
    feed(C_SPACE, 1, 0, NO_WANT);
    quiet = 0;

    // random stylesheets
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      make_sheet();
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < sheet.size(); i++)
        feed(sheet[i], i == sheet.size() - 1, 0, NO_WANT);
      sent += sheet.size();
    end
    quiet       = 0;
    in_ch.valid = 1'b0;

    // drain, then give any stray result time to show
    while (due_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ css_top_level_rule_splitter.f @@
design/crs_pkg.sv
design/crs_in_if.sv
design/crs_out_if.sv
design/crs_in_stage.sv
design/crs_step.sv
design/crs_res_fifo.sv
design/css_top_level_rule_splitter.sv
test/tb_top.sv
